[design/rwsu_pkg.sv]
`timescale 1ns / 1ps
// Package: shared constants, types and codes of the Rprop+ step update engine.
package rwsu_pkg;

    localparam int NUM_WEIGHTS = 4096;
    localparam int ADDR_W      = $clog2(NUM_WEIGHTS);
    localparam int IDX_W       = 12;
    localparam int SIGN_W      = 2;
    localparam int STEP_W      = 24;
    localparam int FACT_W      = 16;
    localparam int DELTA_W     = 25;
    localparam int FRAC_SHIFT  = 14;
    localparam int PROD_W      = STEP_W + FACT_W;
    localparam int RATIO_W     = PROD_W - FRAC_SHIFT;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [STEP_W-1:0] STEP_SAT = '1;

    localparam logic [STEP_W-1:0] RST_INIT_STEP = STEP_W'(6554);
    localparam logic [FACT_W-1:0] RST_GROW      = FACT_W'(19661);
    localparam logic [FACT_W-1:0] RST_SHRINK    = FACT_W'(8192);
    localparam logic [STEP_W-1:0] RST_STEP_MAX  = STEP_W'(3276800);
    localparam logic [STEP_W-1:0] RST_STEP_MIN  = STEP_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_STEP = 3'd0,
        CFG_GROW      = 3'd1,
        CFG_SHRINK    = 3'd2,
        CFG_STEP_MAX  = 3'd3,
        CFG_STEP_MIN  = 3'd4
    } t_cfg_reg;

    // Update class of one item
    typedef enum logic [3:0] {
        OP_INIT   = 4'b0001,
        OP_GROW   = 4'b0010,
        OP_SHRINK = 4'b0100,
        OP_KEEP   = 4'b1000
    } t_op;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_sign             sign;
        logic              first;
    } t_item;

    typedef struct packed {
        logic [STEP_W-1:0] initial_step;
        logic [FACT_W-1:0] grow_factor;
        logic [FACT_W-1:0] shrink_factor;
        logic [STEP_W-1:0] step_max;
        logic [STEP_W-1:0] step_min;
    } t_cfg;

    typedef struct packed {
        t_sign                     prior;
        logic [STEP_W-1:0]         step;
        logic signed [DELTA_W-1:0] delta;
    } t_entry;

endpackage

[design/rwsu_if.sv]
`timescale 1ns / 1ps
// Interfaces: gradient input, update result and register write channels.
interface rwsu_in_if import rwsu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         weight_index;
    logic signed [SIGN_W-1:0] gradient_sign;
    logic                     first_epoch;

    modport source (output valid, weight_index, gradient_sign, first_epoch, input ready);
    modport sink   (input valid, weight_index, gradient_sign, first_epoch, output ready);
endinterface

interface rwsu_out_if import rwsu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] weight_delta;
    logic [STEP_W-1:0]         new_step;
    logic                      sign_flip;

    modport source (output valid, weight_delta, new_step, sign_flip, input ready);
    modport sink   (input valid, weight_delta, new_step, sign_flip, output ready);
endinterface

interface rwsu_cfg_if import rwsu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/rprop_weight_step_update.sv]
`timescale 1ns / 1ps
// Path: an accepted beat goes through the queue, read, update and result registers to o_out.
// Throughput: one beat per cycle while o_out is ready; the weight store is read and written
// once per beat through one read and one write port, with same-weight hazards forwarded.
// Reset: synchronous active-low i_rst_n empties the queue and pipe and loads register defaults.
// The weight store is not cleared: each weight needs a first-epoch beat before normal updates.
module rprop_weight_step_update import rwsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwsu_in_if.sink    i_in,
    rwsu_out_if.source o_out,
    rwsu_cfg_if.sink   i_cfg
);

    // Register file: writes always complete; unknown indexes are dropped.
    t_cfg  r_cfg;
    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_step  <= RST_INIT_STEP;
            r_cfg.grow_factor   <= RST_GROW;
            r_cfg.shrink_factor <= RST_SHRINK;
            r_cfg.step_max      <= RST_STEP_MAX;
            r_cfg.step_min      <= RST_STEP_MIN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_INIT_STEP: r_cfg.initial_step  <= i_cfg.data[STEP_W-1:0];
                CFG_GROW:      r_cfg.grow_factor   <= i_cfg.data[FACT_W-1:0];
                CFG_SHRINK:    r_cfg.shrink_factor <= i_cfg.data[FACT_W-1:0];
                CFG_STEP_MAX:  r_cfg.step_max      <= i_cfg.data[STEP_W-1:0];
                CFG_STEP_MIN:  r_cfg.step_min      <= i_cfg.data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: take a beat, decode the sign into plus/minus flags, hold it in a short queue
    // so the update pipe can stall on the result side without blocking the source at once.
    rwsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    // Back end: read the weight entry, classify against the stored sign and multiply by the
    // grow or shrink factor, then clamp, write back and present the result. The result
    // register advances whenever it is empty or being drained, so beats flow every cycle.
    rwsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .i_cfg        (r_cfg),
        .o_out        (o_out)
    );

endmodule

[design/rwsu_front.sv]
`timescale 1ns / 1ps
// Front end: accept gradient beats, decode the sign and queue them for the update pipe.
module rwsu_front import rwsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwsu_in_if.sink    i_in,
    output t_item      o_head,
    output logic       o_head_valid,
    input  logic       i_pop
);

    t_item               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;
    t_item               w_item;
    logic                w_push;

    // Code 1 is plus, codes 2 and 3 are minus, code 0 is zero
    always_comb begin
        w_item.addr     = i_in.weight_index[ADDR_W-1:0];
        w_item.sign.pos = ~i_in.gradient_sign[1] & i_in.gradient_sign[0];
        w_item.sign.neg = i_in.gradient_sign[1];
        w_item.first    = i_in.first_epoch;
    end

    assign i_in.ready   = (r_count != Q_CNT_W'(Q_DEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head       = r_q[r_rd_ptr];
    assign o_head_valid = (r_count != '0);

    assign n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_head_valid)
        else $error("accepted beat did not reach the queue");

endmodule

[design/rwsu_back.sv]
`timescale 1ns / 1ps
// Back end: weight state memory, read-modify-write update pipe and result register.
module rwsu_back import rwsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_head,
    input  logic       i_head_valid,
    output logic       o_pop,
    input  t_cfg       i_cfg,
    rwsu_out_if.source o_out
);

    typedef struct packed {
        logic [ADDR_W-1:0]         addr;
        t_sign                     sign;
        t_op                       op;
        logic [STEP_W-1:0]         step;
        logic signed [DELTA_W-1:0] delta;
        logic [RATIO_W-1:0]        ratio;
    } t_s2;

    t_entry                    r_mem [NUM_WEIGHTS];
    t_entry                    r_rd;
    logic                      r_s1_v;
    t_item                     r_s1;
    logic                      r_s2_v;
    t_s2                       r_s2;
    logic                      r_wb_v;
    logic [ADDR_W-1:0]         r_wb_addr;
    t_entry                    r_wb;
    logic                      r_out_v;
    logic signed [DELTA_W-1:0] r_out_delta;
    logic [STEP_W-1:0]         r_out_step;
    logic                      r_out_flip;

    logic                      w_adv;
    t_entry                    w_cur;
    t_op                       w_op;
    logic [FACT_W-1:0]         w_factor;
    logic [PROD_W-1:0]         w_prod;
    t_s2                       n_s2;
    logic [STEP_W-1:0]         w_grow_step;
    logic [STEP_W-1:0]         w_shrink_sat;
    logic [STEP_W-1:0]         w_shrink_step;
    t_entry                    n_wr;

    function automatic logic signed [DELTA_W-1:0] f_neg_sign_times(
        input t_sign             s,
        input logic [STEP_W-1:0] st
    );
        logic signed [DELTA_W-1:0] mag;
        mag = $signed(DELTA_W'(st));
        if (s.neg) begin
            return mag;
        end else if (s.pos) begin
            return -mag;
        end
        return '0;
    endfunction

    assign w_adv = !r_out_v || o_out.ready;
    assign o_pop = w_adv && i_head_valid;

    // Stage 2: clamp, form the delta and the entry to write back
    always_comb begin
        w_grow_step   = (r_s2.ratio < RATIO_W'(i_cfg.step_max)) ?
                        r_s2.ratio[STEP_W-1:0] : i_cfg.step_max;
        w_shrink_sat  = (r_s2.ratio > RATIO_W'(STEP_SAT)) ? STEP_SAT : r_s2.ratio[STEP_W-1:0];
        w_shrink_step = (w_shrink_sat > i_cfg.step_min) ? w_shrink_sat : i_cfg.step_min;
        n_wr.prior    = r_s2.sign;
        unique case (r_s2.op)
            OP_INIT:   n_wr.step = i_cfg.initial_step;
            OP_GROW:   n_wr.step = w_grow_step;
            OP_SHRINK: n_wr.step = w_shrink_step;
            OP_KEEP:   n_wr.step = r_s2.step;
            default:   n_wr.step = r_s2.step;
        endcase
        if (r_s2.op == OP_SHRINK) begin
            n_wr.prior = '0;
            n_wr.delta = -r_s2.delta;
        end else begin
            n_wr.delta = f_neg_sign_times(r_s2.sign, n_wr.step);
        end
    end

    // Stage 1: forward the newest copy of the entry, classify and multiply
    always_comb begin
        if (r_s2_v && (r_s2.addr == r_s1.addr)) begin
            w_cur = n_wr;
        end else if (r_wb_v && (r_wb_addr == r_s1.addr)) begin
            w_cur = r_wb;
        end else begin
            w_cur = r_rd;
        end
        if (r_s1.first) begin
            w_op = OP_INIT;
        end else if ((w_cur.prior.pos & r_s1.sign.pos) | (w_cur.prior.neg & r_s1.sign.neg)) begin
            w_op = OP_GROW;
        end else if ((w_cur.prior.pos & r_s1.sign.neg) | (w_cur.prior.neg & r_s1.sign.pos)) begin
            w_op = OP_SHRINK;
        end else begin
            w_op = OP_KEEP;
        end
        w_factor   = (w_op == OP_SHRINK) ? i_cfg.shrink_factor : i_cfg.grow_factor;
        w_prod     = PROD_W'(w_factor) * PROD_W'(w_cur.step);
        n_s2.addr  = r_s1.addr;
        n_s2.sign  = r_s1.sign;
        n_s2.op    = w_op;
        n_s2.step  = w_cur.step;
        n_s2.delta = w_cur.delta;
        n_s2.ratio = w_prod[PROD_W-1:FRAC_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_wb_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= i_head_valid;
            r_s2_v  <= r_s1_v;
            r_wb_v  <= r_s2_v;
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1        <= i_head;
            r_s2        <= n_s2;
            r_wb_addr   <= r_s2.addr;
            r_wb        <= n_wr;
            r_out_delta <= n_wr.delta;
            r_out_step  <= n_wr.step;
            r_out_flip  <= (r_s2.op == OP_SHRINK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_s2_v) begin
                r_mem[r_s2.addr] <= n_wr;
            end
            r_rd <= r_mem[i_head.addr];
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.weight_delta = r_out_delta;
    assign o_out.new_step     = r_out_step;
    assign o_out.sign_flip    = r_out_flip;

    a_grow_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && (r_s2.op == OP_GROW)) |-> (n_wr.step <= i_cfg.step_max))
        else $error("grown step above upper clamp");

    a_shrink_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && (r_s2.op == OP_SHRINK)) |-> ((n_wr.step >= i_cfg.step_min) &&
                                               (n_wr.prior == '0)))
        else $error("shrunk step below lower clamp or sign not cleared");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_v) |=> r_out_v)
        else $error("finished update lost before the result register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_s1_v) && $stable(r_s2_v)))
        else $error("pipe moved while the result register was blocked");

endmodule
